/* rtl/core/histogram_largest_rectangle_defines.svh */
// Shared assertion macros for the histogram rectangle block.
// Each use sits in a module that has clk and arst_n in scope.
`ifndef HISTOGRAM_LARGEST_RECTANGLE_DEFINES_SVH
`define HISTOGRAM_LARGEST_RECTANGLE_DEFINES_SVH

// Same-cycle implication.
`define HLR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define HLR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/hlr_pkg.sv */
package hlr_pkg;

	localparam int MAX_BARS_DEF    = 1024;
	localparam int HEIGHT_BITS_DEF = 16;
	localparam int AREA_OUT_W      = 26;

	// Classification of a queued item.
	typedef struct packed {
		logic last;  // final bar of the histogram
		logic over;  // bar arrived beyond stack capacity
	} cls_t;

endpackage

/* rtl/core/hlr_front.sv */
`include "histogram_largest_rectangle_defines.svh"

module hlr_front #(
	parameter int MAX_BARS    = hlr_pkg::MAX_BARS_DEF,
	parameter int HEIGHT_BITS = hlr_pkg::HEIGHT_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   bar_valid,
	output logic                   bar_stall,
	input  logic [HEIGHT_BITS-1:0] bar_height,
	input  logic                   last_bar,
	output logic                   q_valid,
	input  logic                   q_pop,
	output logic [HEIGHT_BITS-1:0] q_height,
	output hlr_pkg::cls_t          q_cls
);

	localparam int IDX_W = $clog2(MAX_BARS + 1);

	logic [IDX_W-1:0]       cnt_q;
	logic [HEIGHT_BITS-1:0] h_mem [2];
	hlr_pkg::cls_t          cls_mem [2];
	logic                   wp_q;
	logic                   rp_q;
	logic [1:0]             fill_q;
	logic                   acc;
	logic                   over;

	assign bar_stall = (fill_q == 2'd2);
	assign acc       = bar_valid && !bar_stall;
	assign over      = (cnt_q == IDX_W'(MAX_BARS));

	assign q_valid  = (fill_q != 2'd0);
	assign q_height = h_mem[rp_q];
	assign q_cls    = cls_mem[rp_q];

	// Count bars of the current histogram, saturate at capacity; advance the queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			wp_q   <= 1'b0;
			rp_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (acc) begin
				wp_q <= ~wp_q;
				if (last_bar) begin
					cnt_q <= '0;
				end else if (!over) begin
					cnt_q <= cnt_q + IDX_W'(1);
				end
			end
			if (q_pop) begin
				rp_q <= ~rp_q;
			end
			fill_q <= fill_q + {1'b0, acc} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			h_mem[wp_q]   <= bar_height;
			cls_mem[wp_q] <= '{last: last_bar, over: over};
		end
	end

	`HLR_ASSERT_NOW(a_cnt_range, 1'b1, cnt_q <= IDX_W'(MAX_BARS), "bar count beyond capacity")
	`HLR_ASSERT_NOW(a_fill_range, 1'b1, fill_q <= 2'd2, "queue fill beyond depth")
	`HLR_ASSERT_NOW(a_pop_nonempty, q_pop, fill_q != 2'd0, "pop from empty queue")

endmodule

/* rtl/core/hlr_back.sv */
`include "histogram_largest_rectangle_defines.svh"

module hlr_back #(
	parameter int MAX_BARS    = hlr_pkg::MAX_BARS_DEF,
	parameter int HEIGHT_BITS = hlr_pkg::HEIGHT_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                q_valid,
	output logic                                q_pop,
	input  logic [HEIGHT_BITS-1:0]              q_height,
	input  hlr_pkg::cls_t                       q_cls,
	output logic                                area_valid,
	input  logic                                area_stall,
	output logic [hlr_pkg::AREA_OUT_W-1:0]      largest_area,
	output logic                                capacity_exceeded
);

	localparam int IDX_W  = $clog2(MAX_BARS + 1);
	localparam int ADDR_W = $clog2(MAX_BARS);
	localparam int AREA_W = HEIGHT_BITS + IDX_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_POP,
		S_RESULT
	} state_t;

	state_t                       state_q;
	logic [IDX_W-1:0]             depth_q;
	logic [IDX_W-1:0]             bar_index_q;
	logic [HEIGHT_BITS-1:0]       top_h_q;
	logic [HEIGHT_BITS-1:0]       h_q;
	logic                         last_q;
	logic                         flush_q;
	logic                         overflow_q;
	logic [AREA_W-1:0]            best_q;
	logic [AREA_W-1:0]            product_s1;
	logic                         prod_v_q;
	logic                         out_valid_q;
	logic [hlr_pkg::AREA_OUT_W-1:0] out_area_q;
	logic                         out_over_q;

	logic [HEIGHT_BITS-1:0]       stk_h_mem [MAX_BARS];
	logic [ADDR_W-1:0]            stk_p_mem [MAX_BARS];
	logic [HEIGHT_BITS-1:0]       rd_h_q;
	logic [ADDR_W-1:0]            rd_p_q;

	logic [HEIGHT_BITS-1:0]       limit;
	logic                         pop_go;
	logic                         push_go;
	logic [ADDR_W-1:0]            rd_addr;
	logic [IDX_W-1:0]             left;
	logic [IDX_W-1:0]             wid;
	logic                         out_free;
	logic [hlr_pkg::AREA_OUT_W-1:0] area_sat;

	assign q_pop   = (state_q == S_IDLE) && q_valid;
	assign limit   = flush_q ? '0 : h_q;
	assign pop_go  = (state_q == S_CHECK) && (depth_q != '0) && (top_h_q > limit);
	// Depth never exceeds the bar index, so a counted bar always has room.
	assign push_go = (state_q == S_CHECK) && !pop_go && !flush_q;
	// Entry just below the top; meaningless when only one entry is stacked.
	assign rd_addr = ADDR_W'(depth_q - IDX_W'(2));
	assign left    = (depth_q > IDX_W'(1)) ? (IDX_W'(rd_p_q) + IDX_W'(1)) : '0;
	assign wid     = bar_index_q - left;
	assign out_free = !out_valid_q || !area_stall;

	generate
		if (AREA_W > hlr_pkg::AREA_OUT_W) begin : g_sat
			assign area_sat = (|best_q[AREA_W-1:hlr_pkg::AREA_OUT_W]) ? '1
				: best_q[hlr_pkg::AREA_OUT_W-1:0];
		end else begin : g_ext
			assign area_sat = hlr_pkg::AREA_OUT_W'(best_q);
		end
	endgenerate

	assign area_valid        = out_valid_q;
	assign largest_area      = out_area_q;
	assign capacity_exceeded = out_over_q;

	// Stack memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (push_go) begin
			stk_h_mem[ADDR_W'(depth_q)] <= h_q;
			stk_p_mem[ADDR_W'(depth_q)] <= ADDR_W'(bar_index_q);
		end
		rd_h_q <= stk_h_mem[rd_addr];
		rd_p_q <= stk_p_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_POP) begin
			product_s1 <= AREA_W'(top_h_q) * AREA_W'(wid);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			depth_q     <= '0;
			bar_index_q <= '0;
			top_h_q     <= '0;
			h_q         <= '0;
			last_q      <= 1'b0;
			flush_q     <= 1'b0;
			overflow_q  <= 1'b0;
			best_q      <= '0;
			prod_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
			out_area_q  <= '0;
			out_over_q  <= 1'b0;
		end else begin
			prod_v_q <= (state_q == S_POP);
			// Fold the product of the last pop into the best area.
			if (prod_v_q && (product_s1 > best_q)) begin
				best_q <= product_s1;
			end
			if ((state_q == S_RESULT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!area_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						h_q    <= q_height;
						last_q <= q_cls.last;
						if (q_cls.over) begin
							overflow_q <= 1'b1;
							if (q_cls.last) begin
								flush_q <= 1'b1;
								state_q <= S_CHECK;
							end
						end else begin
							flush_q <= 1'b0;
							state_q <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					if (pop_go) begin
						state_q <= S_POP;
					end else if (!flush_q) begin
						top_h_q     <= h_q;
						depth_q     <= depth_q + IDX_W'(1);
						bar_index_q <= bar_index_q + IDX_W'(1);
						if (last_q) begin
							flush_q <= 1'b1;
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						state_q <= S_RESULT;
					end
				end
				S_POP: begin
					depth_q  <= depth_q - IDX_W'(1);
					top_h_q  <= rd_h_q;
					state_q  <= S_CHECK;
				end
				S_RESULT: begin
					if (out_free) begin
						out_area_q  <= area_sat;
						out_over_q  <= overflow_q;
						depth_q     <= '0;
						bar_index_q <= '0;
						best_q      <= '0;
						overflow_q  <= 1'b0;
						flush_q     <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`HLR_ASSERT_NOW(a_depth_le_index, 1'b1, depth_q <= bar_index_q, "stack deeper than bar count")
	`HLR_ASSERT_NOW(a_pop_nonempty, state_q == S_POP, depth_q != '0, "pop on empty stack")
	`HLR_ASSERT_NEXT(a_pop_to_check, state_q == S_POP, state_q == S_CHECK && prod_v_q,
		"pop not followed by area fold")
	`HLR_ASSERT_NOW(a_result_flushed, state_q == S_RESULT,
		flush_q && (depth_q == '0 || top_h_q == '0),
		"result with nonzero entries left on stack")

endmodule

/* rtl/core/histogram_largest_rectangle.sv */
// Channel | valid      | stall      | payload
// --------+------------+------------+-----------------------------------------
// bar in  | bar_valid  | bar_stall  | bar_height, last_bar
// area out| area_valid | area_stall | largest_area, capacity_exceeded
//
// A bar that pops nothing passes the stack engine as a fetch and a push;
// each popped entry adds a compare/read step and a multiply step. The stack
// memory's single read port and the multiplier register set these steps.
// A last bar adds the flush pops plus a final compare and a result load.
// A 2-entry queue after the classifier absorbs bars while the engine pops.
// After reset the block accepts at once; the stack memory needs no clearing.
// A stalled result holds the engine in its result step; the queue fills,
// then bar_stall rises.
module histogram_largest_rectangle #(
	parameter int MAX_BARS    = hlr_pkg::MAX_BARS_DEF,
	parameter int HEIGHT_BITS = hlr_pkg::HEIGHT_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           bar_valid,
	output logic                           bar_stall,
	input  logic [HEIGHT_BITS-1:0]         bar_height,
	input  logic                           last_bar,
	output logic                           area_valid,
	input  logic                           area_stall,
	output logic [hlr_pkg::AREA_OUT_W-1:0] largest_area,
	output logic                           capacity_exceeded
);

	// Handoff between classifier and stack engine.
	logic                   q_valid;
	logic                   q_pop;
	logic [HEIGHT_BITS-1:0] q_height;
	hlr_pkg::cls_t          q_cls;

	// Front: count bars per histogram, flag those past capacity, queue them.
	hlr_front #(
		.MAX_BARS    (MAX_BARS),
		.HEIGHT_BITS (HEIGHT_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.bar_valid  (bar_valid),
		.bar_stall  (bar_stall),
		.bar_height (bar_height),
		.last_bar   (last_bar),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.q_height   (q_height),
		.q_cls      (q_cls)
	);

	// Back: monotonic stack, area per pop, best area, result register.
	hlr_back #(
		.MAX_BARS    (MAX_BARS),
		.HEIGHT_BITS (HEIGHT_BITS)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.q_valid           (q_valid),
		.q_pop             (q_pop),
		.q_height          (q_height),
		.q_cls             (q_cls),
		.area_valid        (area_valid),
		.area_stall        (area_stall),
		.largest_area      (largest_area),
		.capacity_exceeded (capacity_exceeded)
	);

endmodule
